// ----- rtl/core/lfs_pkg.sv -----
// Shared types and constants for the line follower PD steering block.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package lfs_pkg;

  // Sample width of the line and junction sensors
  localparam int ADC_BITS_DEF = 10;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Result word: right, left, steer (12 each), position (4), action (2), count (8)
  localparam int DRIVE_W  = 12;
  localparam int POS_W    = 4;
  localparam int ACT_W    = 2;
  localparam int JCNT_W   = 8;
  localparam int OUT_BITS = 3 * DRIVE_W + POS_W + ACT_W + JCNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Magnitude of a position change fits in four bits (at most ten)
  localparam int DIFF_W    = 4;
  localparam int DIV_STEPS = DIFF_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic signed [POS_W-1:0] POS_LOST = 4'sd5;
  localparam logic [JCNT_W-1:0]       TURN_LAST = 8'd2;

  // Configuration reset values
  localparam logic [9:0]  LINE_THR_RST  = 10'd300;
  localparam logic [9:0]  JUNC_THR_RST  = 10'd200;
  localparam logic [9:0]  KP_RST        = 10'd150;
  localparam logic [9:0]  KD_RST        = 10'd7;
  localparam logic [10:0] BASE_RST      = 11'd568;
  localparam logic [7:0]  DEB_LIM_RST   = 8'd10;
  localparam logic [15:0] START_RST     = 16'd50000;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE  = 2'd0,
    ACT_TURN  = 2'd1,
    ACT_ALIGN = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_THR = 3'd0,
    REG_JUNC_THR = 3'd1,
    REG_KP       = 3'd2,
    REG_KD       = 3'd3,
    REG_BASE     = 3'd4,
    REG_DEB_LIM  = 3'd5,
    REG_START    = 3'd6
  } reg_idx_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    logic sum;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/lfs_ctrl.sv -----
// Sequencer for the line follower: load, divide steps, multiply, sum, emit.
// Depends on lfs_pkg for the command and status structs.
`default_nettype none

module lfs_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  lfs_pkg::sts_t    sts_i,
  output lfs_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_EMIT
  } state_e;

  localparam logic [lfs_pkg::DIV_CNT_W-1:0] CNT_LAST =
    lfs_pkg::DIV_CNT_W'(lfs_pkg::DIV_STEPS - 1);

  state_e state_q;
  logic [lfs_pkg::DIV_CNT_W-1:0] cnt_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.sum      = (state_q == ST_SUM);
    cmd_o.emit     = (state_q == ST_EMIT) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_DIV;
            cnt_q   <= '0;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) state_q <= ST_MUL;
        end
        ST_MUL:  state_q <= ST_SUM;
        ST_SUM:  state_q <= ST_EMIT;
        ST_EMIT: begin
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lfs_datapath.sv -----
// Datapath: configuration registers, tracking state, serial divider, PD maths
// and the output register. Depends on lfs_pkg; driven by lfs_ctrl commands.
`default_nettype none

module lfs_datapath #(
  parameter int ADC_BITS = lfs_pkg::ADC_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [lfs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [lfs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire  [4*ADC_BITS-1:0]              samples_i,
  input  lfs_pkg::cmd_t                      cmd_i,
  output lfs_pkg::sts_t                      sts_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [lfs_pkg::OUT_W-1:0]          out_data_o
);

  localparam int THR_W = 10;
  localparam int CMP_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;
  localparam int PAD_W = lfs_pkg::OUT_W - lfs_pkg::OUT_BITS;
  localparam int DW    = lfs_pkg::DIFF_W;

  // Configuration
  logic [9:0]  line_thr_q, junc_thr_q, kp_q, kd_q;
  logic [10:0] base_q;
  logic [7:0]  deb_lim_q;
  logic [15:0] start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_thr_q <= lfs_pkg::LINE_THR_RST;
      junc_thr_q <= lfs_pkg::JUNC_THR_RST;
      kp_q       <= lfs_pkg::KP_RST;
      kd_q       <= lfs_pkg::KD_RST;
      base_q     <= lfs_pkg::BASE_RST;
      deb_lim_q  <= lfs_pkg::DEB_LIM_RST;
      start_q    <= lfs_pkg::START_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lfs_pkg::REG_LINE_THR: line_thr_q <= cfg_data_i[9:0];
        lfs_pkg::REG_JUNC_THR: junc_thr_q <= cfg_data_i[9:0];
        lfs_pkg::REG_KP:       kp_q       <= cfg_data_i[9:0];
        lfs_pkg::REG_KD:       kd_q       <= cfg_data_i[9:0];
        lfs_pkg::REG_BASE:     base_q     <= cfg_data_i[10:0];
        lfs_pkg::REG_DEB_LIM:  deb_lim_q  <= cfg_data_i[7:0];
        lfs_pkg::REG_START:    start_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sensor decode
  logic [CMP_W-1:0] ll, rl, lj, rj, lthr, jthr;
  assign ll   = CMP_W'(samples_i[ADC_BITS-1:0]);
  assign rl   = CMP_W'(samples_i[2*ADC_BITS-1:ADC_BITS]);
  assign lj   = CMP_W'(samples_i[3*ADC_BITS-1:2*ADC_BITS]);
  assign rj   = CMP_W'(samples_i[4*ADC_BITS-1:3*ADC_BITS]);
  assign lthr = CMP_W'(line_thr_q);
  assign jthr = CMP_W'(junc_thr_q);

  // Tracking state
  logic signed [3:0] prev_pos_q;
  logic [15:0]       span_q, follow_q;
  logic              parity_q;
  logic [7:0]        deb_q, jseen_q;

  logic              left_on, right_on, detecting, hit, changed;
  logic signed [3:0] pos_c;
  logic signed [4:0] diff_c, diff_abs;
  logic [15:0]       span_inc, follow_inc;
  logic [7:0]        deb_inc, jseen_inc;
  lfs_pkg::action_e  act_c;

  always_comb begin
    left_on    = ll >= lthr;
    right_on   = rl >= lthr;
    detecting  = follow_q >= start_q;
    hit        = detecting && ((lj >= jthr) || (rj >= jthr)) &&
                 (left_on || right_on) && (deb_q > deb_lim_q);
    jseen_inc  = (&jseen_q) ? jseen_q : jseen_q + 8'd1;
    deb_inc    = (&deb_q) ? deb_q : deb_q + 8'd1;
    span_inc   = (&span_q) ? span_q : span_q + 16'd1;
    follow_inc = (&follow_q) ? follow_q : follow_q + 16'd1;
    if (!hit)                               act_c = lfs_pkg::ACT_NONE;
    else if (jseen_inc <= lfs_pkg::TURN_LAST) act_c = lfs_pkg::ACT_TURN;
    else                                    act_c = lfs_pkg::ACT_ALIGN;
    // Lost line: keep to the side seen last
    if (left_on && right_on) pos_c = 4'sd0;
    else if (left_on)        pos_c = 4'sd1;
    else if (right_on)       pos_c = -4'sd1;
    else if (prev_pos_q[3])  pos_c = -lfs_pkg::POS_LOST;
    else                     pos_c = lfs_pkg::POS_LOST;
    changed  = pos_c != prev_pos_q;
    diff_c   = {pos_c[3], pos_c} - {prev_pos_q[3], prev_pos_q};
    diff_abs = diff_c[4] ? -diff_c : diff_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pos_q <= '0;
      span_q     <= '0;
      parity_q   <= 1'b0;
      follow_q   <= '0;
      deb_q      <= '0;
      jseen_q    <= '0;
    end else if (cmd_i.load) begin
      prev_pos_q <= pos_c;
      // Restart the span on every second change, after its value went to the divider
      span_q     <= (changed && parity_q) ? 16'd0 : span_inc;
      parity_q   <= parity_q ^ changed;
      if (hit) jseen_q <= jseen_inc;
      if (detecting) deb_q <= hit ? 8'd1 : deb_inc;
      else           follow_q <= follow_inc;
    end
  end

  // Item registers and restoring divider, one quotient bit a step
  logic signed [3:0] pos_q;
  logic [1:0]        act_q;
  logic [7:0]        jcnt_q;
  logic              neg_q;
  logic [DW-1:0]     quo_q, rem_q;
  logic [15:0]       div_q;
  logic [DW:0]       trial;
  logic              ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = 16'(trial) >= div_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q  <= pos_c;
      act_q  <= act_c;
      jcnt_q <= hit ? jseen_inc : jseen_q;
      neg_q  <= diff_c[4];
      quo_q  <= diff_abs[DW-1:0];
      rem_q  <= '0;
      div_q  <= span_inc;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? DW'(trial - div_q[DW:0]) : trial[DW-1:0];
    end
  end

  // PD terms
  logic signed [10:0] kp_s, kd_s;
  logic signed [4:0]  deriv_c;
  logic signed [14:0] pp_q;
  logic signed [15:0] dp_q;
  logic signed [16:0] pd_q;

  assign kp_s    = {1'b0, kp_q};
  assign kd_s    = {1'b0, kd_q};
  assign deriv_c = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      pp_q <= 15'(kp_s) * 15'(pos_q);
      dp_q <= 16'(kd_s) * 16'(deriv_c);
    end
    if (cmd_i.sum) pd_q <= 17'(pp_q) + 17'(dp_q);
  end

  // Clamp and drive
  logic signed [16:0] lim, clamped, right_c, left_c;
  always_comb begin
    lim = $signed({6'd0, base_q});
    if (pd_q > lim)       clamped = lim;
    else if (pd_q < -lim) clamped = -lim;
    else                  clamped = pd_q;
    right_c = lim + clamped;
    left_c  = lim - clamped;
  end

  logic        out_valid_q;
  logic [11:0] right_q, left_q, steer_q;
  logic [3:0]  pos_out_q;
  logic [1:0]  act_out_q;
  logic [7:0]  jcnt_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.emit) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      right_q    <= right_c[11:0];
      left_q     <= left_c[11:0];
      steer_q    <= clamped[11:0];
      pos_out_q  <= pos_q;
      act_out_q  <= act_q;
      jcnt_out_q <= jcnt_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = {{PAD_W{1'b0}}, jcnt_out_q, act_out_q, pos_out_q,
                           steer_q, left_q, right_q};

`ifndef NO_ASSERTIONS
  a_steer_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($signed(steer_q) <= $signed({1'b0, base_q}) &&
                     $signed(steer_q) >= -$signed({1'b0, base_q})))
    else $error("steer outside base speed clamp");
  a_drive_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (12'(right_q + left_q) == 12'({base_q, 1'b0})))
    else $error("drives do not sum to twice base speed");
  a_span_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (span_q == 16'd0) |-> !parity_q)
    else $error("span cleared with a change still pending");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/line_follow_pd_steering.sv -----
// Top level of the two-sensor line follower with PD steering and junction count.
// Depends on lfs_pkg, lfs_ctrl and lfs_datapath.
//
//   channel   dir  handshake                        payload
//   s_axis    in   s_axis_tvalid_i / s_axis_tready_o  s_axis_tdata_i (four ADC samples)
//   m_axis    out  m_axis_tvalid_o / m_axis_tready_i  m_axis_tdata_o (drives, steer, codes)
//   cfg       in   cfg_valid_i / cfg_ready_o          cfg_index_i, cfg_data_i
//
// An item passes from acceptance to its result through one load step, four
// steps of the restoring divider (one quotient bit each, set by the four-bit
// position change), then multiply, sum and clamp/emit. One item is in flight
// at a time; the next is taken as soon as the result sits in the output
// register, even while that result is still waiting on m_axis_tready_i.
// Reset is asynchronous and active low; configuration is always ready.
`default_nettype none

module line_follow_pd_steering #(
  parameter int ADC_BITS = lfs_pkg::ADC_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // fields, low bit up: left_line, right_line, left_junction, right_junction
  input  wire  [((4*ADC_BITS+7)/8)*8-1:0]  s_axis_tdata_i,
  input  wire                              s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // fields, low bit up: right_drive, left_drive, steer, line_position,
  // junction_action, junction_count
  output logic [lfs_pkg::OUT_W-1:0]        m_axis_tdata_o,
  output logic                             m_axis_tvalid_o,
  input  wire                              m_axis_tready_i,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [lfs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [lfs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  lfs_pkg::cmd_t cmd;
  lfs_pkg::sts_t sts;

  // Registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  // Sequencer: hold the input side closed while an item is in flight
  lfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: drop the byte padding of the input word here
  lfs_datapath #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .samples_i   (s_axis_tdata_i[4*ADC_BITS-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// ----- bench/tb_line_follow_pd_steering.sv -----
// Self-checking bench for line_follow_pd_steering: directed sensor words, then track-like
// random runs over several register settings, checked against a behavioural steering law.
// Depends on lfs_pkg and the line_follow_pd_steering RTL.
`default_nettype none

module tb_line_follow_pd_steering;
  timeunit 1ns;
  timeprecision 1ps;

  // Result word as it sits in m_axis_tdata_o, highest field first
  typedef struct packed {
    logic [lfs_pkg::JCNT_W-1:0]         jcount;
    lfs_pkg::action_e                   act;
    logic signed [lfs_pkg::POS_W-1:0]   pos;
    logic signed [lfs_pkg::DRIVE_W-1:0] steer;
    logic [lfs_pkg::DRIVE_W-1:0]        left_drv;
    logic [lfs_pkg::DRIVE_W-1:0]        right_drv;
  } drive_word_t;

  localparam int IN_W       = 40;
  localparam int STALL_LEN  = 400;
  localparam int SETTLE_CYC = 12;

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic [IN_W-1:0]                s_tdata     = '0;
  logic                           s_tvalid    = 1'b0;
  logic                           s_tready;
  logic [lfs_pkg::OUT_W-1:0]      m_tdata;
  logic                           m_tvalid;
  logic                           m_tready    = 1'b0;
  logic                           cfg_valid   = 1'b0;
  logic                           cfg_ready;
  logic [lfs_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [lfs_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  line_follow_pd_steering i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow registers and state of the steering law
  // ---------------------------------------------------------------------------
  logic [9:0]              thr_line   = lfs_pkg::LINE_THR_RST;
  logic [9:0]              thr_junc   = lfs_pkg::JUNC_THR_RST;
  logic [9:0]              gain_p     = lfs_pkg::KP_RST;
  logic [9:0]              gain_d     = lfs_pkg::KD_RST;
  logic [10:0]             base_duty  = lfs_pkg::BASE_RST;
  logic [7:0]              deb_limit  = lfs_pkg::DEB_LIM_RST;
  logic [15:0]             start_at   = lfs_pkg::START_RST;

  logic signed [lfs_pkg::POS_W-1:0] last_pos = '0;
  logic [15:0]             span_ticks   = '0;
  logic                    odd_change   = 1'b0;
  logic [15:0]             follow_ticks = '0;
  logic [7:0]              deb_ticks    = '0;
  logic [7:0]              junc_seen    = '0;

  drive_word_t drive_words_due[$];
  int          words_sent  = 0;
  int          mismatches  = 0;
  int          stall_req   = 0;
  int          stall_ack   = 0;
  int          hold_left   = 0;

  // Advance the law by one sensor tick and return the word it should produce
  function automatic drive_word_t follower_tick(input logic [9:0] ll, rl, lj, rj);
    drive_word_t      w;
    logic             lon, ron, detect, jn;
    int               pos, slope, pd, lim;
    lfs_pkg::action_e act;
    lon    = ll >= thr_line;
    ron    = rl >= thr_line;
    detect = follow_ticks >= start_at;
    act    = lfs_pkg::ACT_NONE;
    // Junction check comes before the steering update
    if (detect) begin
      jn = (lj >= thr_junc) || (rj >= thr_junc);
      if (jn && (lon || ron) && deb_ticks > deb_limit) begin
        if (junc_seen != 8'd255) junc_seen = junc_seen + 8'd1;
        deb_ticks = '0;
        act = (junc_seen <= lfs_pkg::TURN_LAST) ? lfs_pkg::ACT_TURN : lfs_pkg::ACT_ALIGN;
      end
    end
    if (span_ticks != 16'hFFFF) span_ticks = span_ticks + 16'd1;
    if (lon && ron)      pos = 0;
    else if (lon)        pos = 1;
    else if (ron)        pos = -1;
    else if (last_pos < 0) pos = -5;
    else                 pos = 5;
    // Integer division truncates toward zero, as the block does
    slope = (pos - int'(last_pos)) / int'(span_ticks);
    pd    = int'(gain_p) * pos + int'(gain_d) * slope;
    lim   = int'(base_duty);
    if (pd > lim)       pd = lim;
    else if (pd < -lim) pd = -lim;
    // Restart the span on every second change of position
    if (pos != int'(last_pos)) begin
      if (odd_change) begin
        span_ticks = '0;
        odd_change = 1'b0;
      end else begin
        odd_change = 1'b1;
      end
    end
    last_pos = 4'(pos);
    if (detect) begin
      if (deb_ticks != 8'd255) deb_ticks = deb_ticks + 8'd1;
    end else if (follow_ticks != 16'hFFFF) begin
      follow_ticks = follow_ticks + 16'd1;
    end
    w.right_drv = 12'(lim + pd);
    w.left_drv  = 12'(lim - pd);
    w.steer     = 12'(pd);
    w.pos       = 4'(pos);
    w.act       = act;
    w.jcount    = junc_seen;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Pacing: sender and receiver idle shares by stage of the run
  // ---------------------------------------------------------------------------
  function automatic int send_idle_pct();
    if (words_sent < 330) return 23;
    if (words_sent < 660) return 84;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (words_sent < 330) return 84;
    if (words_sent < 660) return 23;
    return 0;
  endfunction

  // Receiver: random ready, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (stall_ack != stall_req) begin
      stall_ack = stall_req;
      hold_left = STALL_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: compare each accepted word with the oldest one due
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_words
    drive_word_t got, want;
    logic        bad;
    if (rst_n && m_tvalid && m_tready) begin
      got = m_tdata[lfs_pkg::OUT_BITS-1:0];
      if (drive_words_due.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("%0t: result word with none due: %h", $realtime, m_tdata);
      end else begin
        want = drive_words_due.pop_front();
        bad = (got.right_drv !== want.right_drv) || (got.left_drv !== want.left_drv) ||
              (got.steer !== want.steer) || (got.pos !== want.pos) ||
              (got.act !== want.act) || (got.jcount !== want.jcount) ||
              (m_tdata[lfs_pkg::OUT_W-1:lfs_pkg::OUT_BITS] !== '0);
        if (bad) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("%0t: mismatch right %0d/%0d left %0d/%0d steer %0d/%0d (exp/got)",
                     $realtime, want.right_drv, got.right_drv, want.left_drv, got.left_drv,
                     want.steer, got.steer);
            $display("    pos %0d/%0d action %0d/%0d count %0d/%0d pad %h",
                     want.pos, got.pos, want.act, got.act, want.jcount, got.jcount,
                     m_tdata[lfs_pkg::OUT_W-1:lfs_pkg::OUT_BITS]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------
  // Offer one sensor word, after a random gap, and hold it until taken
  task automatic send_sample(input logic [9:0] ll, rl, lj, rj);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct()) gap = gap + 1;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {rj, lj, rl, ll};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    drive_words_due.push_back(follower_tick(ll, rl, lj, rj));
    words_sent = words_sent + 1;
  endtask

  // Drop valid and wait until every due word has come back
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (drive_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input lfs_pkg::reg_idx_e idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lfs_pkg::REG_LINE_THR: thr_line  = val[9:0];
      lfs_pkg::REG_JUNC_THR: thr_junc  = val[9:0];
      lfs_pkg::REG_KP:       gain_p    = val[9:0];
      lfs_pkg::REG_KD:       gain_d    = val[9:0];
      lfs_pkg::REG_BASE:     base_duty = val[10:0];
      lfs_pkg::REG_DEB_LIM:  deb_limit = val[7:0];
      lfs_pkg::REG_START:    start_at  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(input logic [9:0] lt, jt, kp, kd, input logic [10:0] base,
                              input logic [7:0] dl, input logic [15:0] st);
    settle();
    write_reg(lfs_pkg::REG_LINE_THR, 16'(lt));
    write_reg(lfs_pkg::REG_JUNC_THR, 16'(jt));
    write_reg(lfs_pkg::REG_KP, 16'(kp));
    write_reg(lfs_pkg::REG_KD, 16'(kd));
    write_reg(lfs_pkg::REG_BASE, 16'(base));
    write_reg(lfs_pkg::REG_DEB_LIM, 16'(dl));
    write_reg(lfs_pkg::REG_START, st);
  endtask

  function automatic logic [9:0] adc_on(input logic [9:0] thr);
    return 10'($urandom_range(1023, thr));
  endfunction

  function automatic logic [9:0] adc_off(input logic [9:0] thr);
    if (thr == 0) return 10'd0;
    return 10'($urandom_range(thr - 1, 0));
  endfunction

  function automatic logic [9:0] adc_noise();
    case ($urandom_range(7))
      0:       return 10'd0;
      1:       return 10'd1023;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  // Runs of one line pattern, as a robot on tape sees them, with some noise words
  task automatic drive_track(input int n, input int junc_pct);
    int         run_left, pattern;
    logic [9:0] ll, rl, lj, rj;
    run_left = 0;
    pattern  = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 20) begin
        ll = adc_noise();
        rl = adc_noise();
        lj = adc_noise();
        rj = adc_noise();
      end else begin
        if (run_left == 0) begin
          pattern  = $urandom_range(3);
          run_left = $urandom_range(8, 1);
        end
        run_left = run_left - 1;
        ll = pattern[0] ? adc_on(thr_line) : adc_off(thr_line);
        rl = pattern[1] ? adc_on(thr_line) : adc_off(thr_line);
        lj = adc_off(thr_junc);
        rj = adc_off(thr_junc);
        if ($urandom_range(99) < junc_pct) begin
          if ($urandom_range(1)) lj = adc_on(thr_junc);
          else                   rj = adc_on(thr_junc);
        end
      end
      send_sample(ll, rl, lj, rj);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings: position codes, lost-line memory, threshold edges
  task automatic test_position_codes();
    send_sample(10'd0, 10'd0, 10'd0, 10'd0);
    send_sample(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    send_sample(10'd1023, 10'd0, 10'd0, 10'd0);
    send_sample(10'd0, 10'd1023, 10'd0, 10'd0);
    send_sample(10'd0, 10'd0, 10'd0, 10'd0);
    send_sample(10'd0, 10'd0, 10'd1023, 10'd0);
    send_sample(10'd300, 10'd299, 10'd0, 10'd0);
    send_sample(10'd299, 10'd300, 10'd0, 10'd0);
    send_sample(10'd0, 10'd0, 10'd0, 10'd1023);
    send_sample(10'd1023, 10'd0, 10'd0, 10'd0);
  endtask

  // Early detection: turn for the first two junctions, align after that
  task automatic test_junction_actions();
    program_regs(10'd0, 10'd1023, lfs_pkg::KP_RST, lfs_pkg::KD_RST, lfs_pkg::BASE_RST,
                 8'd0, 16'd3);
    send_sample(10'd0, 10'd0, 10'd1023, 10'd0);
    send_sample(10'd0, 10'd0, 10'd0, 10'd1023);
    send_sample(10'd7, 10'd7, 10'd1022, 10'd1022);
    send_sample(10'd5, 10'd5, 10'd1023, 10'd1023);
    send_sample(10'd1023, 10'd1023, 10'd1023, 10'd0);
  endtask

  // Raise the start count past the ticks already followed: following resumes
  task automatic test_mode_resume();
    settle();
    write_reg(lfs_pkg::REG_START, 16'(follow_ticks + 16'd2));
    repeat (3) send_sample(10'd1023, 10'd1023, 10'd1023, 10'd1023);
  endtask

  // Debounce limit at its maximum never lets a junction count
  task automatic test_debounce_max();
    settle();
    write_reg(lfs_pkg::REG_DEB_LIM, 16'd255);
    repeat (4) send_sample(10'd1023, 10'd1023, 10'd1023, 10'd1023);
  endtask

  // Plain following with full gains and a base of 1024: heavy clamping
  task automatic test_following_extremes();
    program_regs(10'd1023, 10'd1023, 10'd1023, 10'd1023, 11'd1024, 8'd10, 16'd65535);
    drive_track(100, 30);
  endtask

  // No base speed and no proportional gain: drives pinned at zero
  task automatic test_gain_floor();
    program_regs(10'($urandom_range(1023)), 10'($urandom_range(1023)), 10'd0,
                 10'($urandom_range(1023)), 11'd0, 8'($urandom_range(254)), 16'd65535);
    drive_track(60, 30);
  endtask

  // Junction threshold zero and no debounce: the junction count saturates
  task automatic test_junction_saturation();
    program_regs(10'($urandom_range(40)), 10'd0, 10'($urandom_range(1023)),
                 10'($urandom_range(1023)), 11'($urandom_range(1024)), 8'd0, 16'd0);
    drive_track(360, 50);
  endtask

  // Debounce limit one below its maximum: the debounce count saturates before a junction counts
  task automatic test_debounce_saturation();
    program_regs(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                 10'($urandom_range(1023)), 10'($urandom_range(1023)),
                 11'($urandom_range(1024)), 8'd254, 16'd0);
    drive_track(280, 40);
  endtask

  // Random settings, start count around the ticks already followed
  task automatic test_random_settings();
    repeat (3) begin
      program_regs(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                   10'($urandom_range(1023)), 10'($urandom_range(1023)),
                   11'($urandom_range(1024)), 8'($urandom_range(254)),
                   16'($urandom_range(int'(follow_ticks) + 40, 0)));
      drive_track(50, 35);
    end
  endtask

  // Hold the receiver off while words keep coming, then pause the sender
  task automatic test_backpressure();
    settle();
    stall_req = stall_req + 1;
    drive_track(16, 30);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_position_codes();
    test_junction_actions();
    test_mode_resume();
    test_debounce_max();
    test_following_extremes();
    test_gain_floor();
    test_junction_saturation();
    test_debounce_saturation();
    test_random_settings();
    test_backpressure();
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && drive_words_due.size() == 0) begin
      $display("tb_line_follow_pd_steering OK");
    end else begin
      $display("tb_line_follow_pd_steering NOT OK");
    end
    $finish;
  end

  // A correct run ends well before this timeout fires
  initial begin
    #10_000_000;
    $display("tb_line_follow_pd_steering NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// ----- line_follow_pd_steering.f -----
rtl/core/lfs_pkg.sv
rtl/core/lfs_ctrl.sv
rtl/core/lfs_datapath.sv
rtl/core/line_follow_pd_steering.sv
bench/tb_line_follow_pd_steering.sv
